>>> hdl/bubble_sort_ascending_core_assert.svh
// assertion macros for the bubble sort core
`ifndef BUBBLE_SORT_ASCENDING_CORE_ASSERT_SVH
`define BUBBLE_SORT_ASCENDING_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BSA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsa check failed in same cycle");
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsa check failed in next cycle");
`else
`define BSA_ASSERT_SAME(label, clk, rst, ante, cons)
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/bsa_pkg.sv
// shared types and constants for the bubble sort core
package bsa_pkg;

  localparam int BSA_VALUE_W      = 32;
  localparam int BSA_MAX_ELEMENTS = 64;

  typedef struct packed {
    logic                          valid;
    logic                          lt;
    logic signed [BSA_VALUE_W-1:0] value;
  } cell_link_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_cmd_t;

endpackage

>>> hdl/bsa_cell.sv
// one sorting cell: parallel insert of a new element, shift toward the head on drain
module bsa_cell (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bsa_pkg::cell_cmd_t                     cmd,
  input  logic signed [bsa_pkg::BSA_VALUE_W-1:0] x,
  input  bsa_pkg::cell_link_t                    prev,
  input  bsa_pkg::cell_link_t                    next,
  output bsa_pkg::cell_link_t                    self
);
  import bsa_pkg::*;

  logic                          valid;
  logic                          valid_next;
  logic signed [BSA_VALUE_W-1:0] value;
  logic signed [BSA_VALUE_W-1:0] value_next;
  logic                          lt;

  // empty cell counts as larger than anything; equal values stay put
  assign lt = !valid || ($signed(x) < $signed(value));

  assign self = '{valid: valid, lt: lt, value: value};

  always_comb begin
    valid_next = valid;
    value_next = value;
    if (cmd.shift) begin
      valid_next = next.valid;
      value_next = next.value;
    end else if (cmd.insert) begin
      if (prev.lt) begin
        valid_next = prev.valid;
        value_next = prev.value;
      end else if (lt) begin
        valid_next = 1'b1;
        value_next = x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> hdl/bubble_sort_ascending_core.sv
// top level of the bubble sort core: row of sorting cells and load/drain control
//
//  channel  dir  signals                        payload
//  s_*      in   s_tvalid s_tready s_tdata s_tlast   element, last of set
//  m_*      out  m_tvalid m_tready m_tdata m_tlast m_tuser  sorted element, last, dropped
//
//  load: one element per cycle, inserted in place across all cells in that cycle unless full
//  drain: one result per cycle from the head cell, the row shifts toward it
//  a set is loaded completely before its first result is drained
//  s_tready is low while draining; m_tready low holds the head cell
//  reset empties every cell
module bubble_sort_ascending_core #(
  parameter int MAX_ELEMENTS = bsa_pkg::BSA_MAX_ELEMENTS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bsa_pkg::BSA_VALUE_W-1:0]    s_tdata,  // [31:0] value
  input  logic                               s_tlast,  // final_req
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bsa_pkg::BSA_VALUE_W-1:0]    m_tdata,  // [31:0] sorted_value
  output logic                               m_tlast,  // final_res
  output logic                               m_tuser   // [0] dropped
);
  import bsa_pkg::*;

  `include "bubble_sort_ascending_core_assert.svh"

  typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

  state_t     state;
  logic       overflow;
  cell_cmd_t  cmd;
  cell_link_t link [MAX_ELEMENTS];
  cell_link_t prev_link [MAX_ELEMENTS];
  cell_link_t next_link [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] valid_vec;
  logic       full;
  logic       in_req;
  logic       out_req;

  localparam cell_link_t EdgeLink = '{valid: 1'b0, lt: 1'b0, value: '0};

  genvar i;
  generate
    for (i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign prev_link[i] = EdgeLink;
      end else begin : g_mid
        assign prev_link[i] = link[i-1];
      end
      if (i == MAX_ELEMENTS - 1) begin : g_tail
        assign next_link[i] = EdgeLink;
      end else begin : g_body
        assign next_link[i] = link[i+1];
      end
      assign valid_vec[i] = link[i].valid;

      bsa_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .cmd  (cmd),
        .x    ($signed(s_tdata)),
        .prev (prev_link[i]),
        .next (next_link[i]),
        .self (link[i])
      );
    end
  endgenerate

  assign full     = link[MAX_ELEMENTS-1].valid;
  assign s_tready = (state == ST_LOAD);
  assign m_tvalid = (state == ST_DRAIN);
  assign in_req   = s_tvalid && s_tready;
  assign out_req  = m_tvalid && m_tready;

  assign cmd = '{insert: in_req && !full, shift: out_req};

  assign m_tdata = link[0].value;
  assign m_tlast = !link[1].valid;
  assign m_tuser = overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      overflow <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_req && full) begin
            overflow <= 1'b1;
          end
          if (in_req && s_tlast) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_req && m_tlast) begin
            state    <= ST_LOAD;
            overflow <= 1'b0;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  `BSA_ASSERT_SAME(a_drain_ascending, clk, rst, m_tvalid && !m_tlast,
                   $signed(link[0].value) <= $signed(link[1].value))
  `BSA_ASSERT_SAME(a_cells_packed, clk, rst, 1'b1,
                   ((valid_vec >> 1) & ~valid_vec) == '0)
  `BSA_ASSERT_NEXT(a_final_starts_drain, clk, rst, in_req && s_tlast,
                   m_tvalid && link[0].valid)
  `BSA_ASSERT_NEXT(a_last_ends_drain, clk, rst, out_req && m_tlast,
                   !m_tvalid && s_tready && !link[0].valid && !m_tuser)

endmodule
